// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, opcodes and controller/datapath types for the text
// console controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // fixed widths of the channel fields
    localparam int OPCODE_W       = 4;
    localparam int BYTE_W         = 8;
    localparam int CELL_W         = 16;
    localparam int CURSOR_COL_W   = 7;
    localparam int CURSOR_ROW_W   = 5;
    localparam int CURSOR_INDEX_W = 11;

    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_ATTR = 8'h0A;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT    = 4'd0,
        OP_BKSP   = 4'd1,
        OP_SETCUR = 4'd2,
        OP_LEFT   = 4'd3,
        OP_RIGHT  = 4'd4,
        OP_PUTAT  = 4'd5,
        OP_CLEAR  = 4'd6,
        OP_SHOW   = 4'd7,
        OP_READ   = 4'd8
    } t_opcode;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       ptr_zero;
        logic       copy_step;
        logic       fill_step;
        logic       fill_init;
        logic       emit;
        logic [1:0] beat;
        logic       last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_clear;
        logic op_bksp;
        logic exec_scroll;
        logic ptr_copy_end;
        logic ptr_end;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic                      echo_valid;
        logic [BYTE_W-1:0]         echo_byte;
        logic [CELL_W-1:0]         cell_data;
        logic [CURSOR_COL_W-1:0]   cursor_col;
        logic [CURSOR_ROW_W-1:0]   cursor_row;
        logic [CURSOR_INDEX_W-1:0] cursor_index;
        logic                      cursor_shown;
        logic                      last;
    } t_rsp;

    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        cell_index = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/core/tcc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// tcc_cmd_if
// Operation channel into the console: valid/ready plus one operation word.
// ----------------------------------------------------------------------------
interface tcc_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [7:0] char_code;
    logic [7:0] col_arg;
    logic [7:0] row_arg;
    logic [7:0] move_count;

    modport source (output valid, output opcode, output char_code, output col_arg,
                    output row_arg, output move_count, input ready);
    modport sink   (input valid, input opcode, input char_code, input col_arg,
                    input row_arg, input move_count, output ready);
endinterface

// ===== rtl/core/tcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcc_rsp_if
// Result channel out of the console: valid/ready plus one result word.
// ----------------------------------------------------------------------------
interface tcc_rsp_if;
    logic        valid;
    logic        ready;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_index;
    logic        cursor_shown;
    logic        last;

    modport source (output valid, output echo_valid, output echo_byte, output cell_data,
                    output cursor_col, output cursor_row, output cursor_index,
                    output cursor_shown, output last, input ready);
    modport sink   (input valid, input echo_valid, input echo_byte, input cell_data,
                    input cursor_col, input cursor_row, input cursor_index,
                    input cursor_shown, input last, output ready);
endinterface

// ===== rtl/core/tcc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tcc_cfg_if
// Colour register write channel: valid/ready plus the attribute byte.
// ----------------------------------------------------------------------------
interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcc_ctrl
// Sequencer for the console: init sweep, operation execute, scroll copy,
// row/screen fill and result beats.
// ----------------------------------------------------------------------------
module tcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  tcc_pkg::t_sts i_sts,
    output tcc_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_RESP
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_beat, n_beat;

    always_comb begin
        n_state    = r_state;
        n_beat     = r_beat;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.fill_init = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_beat     = 2'd0;
                if (i_sts.op_clear) begin
                    o_cmd.ptr_zero = 1'b1;
                    n_state        = ST_FILL;
                end else if (i_sts.exec_scroll) begin
                    o_cmd.ptr_zero = 1'b1;
                    n_state        = ST_COPY;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.ptr_copy_end) begin
                    n_state = ST_DRAIN;
                end
            end
            // last copied word is written here
            ST_DRAIN: begin
                n_state = ST_FILL;
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.ptr_end) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.beat = r_beat;
                    o_cmd.last = !i_sts.op_bksp || (r_beat == 2'd2);
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_beat = r_beat + 2'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_beat  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_beat  <= n_beat;
        end
    end

endmodule

// ===== rtl/core/tcc_datapath.sv =====
// ----------------------------------------------------------------------------
// tcc_datapath
// Cell store, cursor and colour registers, sweep pointer and result
// register of the console.
// ----------------------------------------------------------------------------
module tcc_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcc_pkg::t_cmd                i_cmd,
    output tcc_pkg::t_sts                o_sts,
    input  logic [tcc_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [tcc_pkg::BYTE_W-1:0]   i_char_code,
    input  logic [tcc_pkg::BYTE_W-1:0]   i_col_arg,
    input  logic [tcc_pkg::BYTE_W-1:0]   i_row_arg,
    input  logic [tcc_pkg::BYTE_W-1:0]   i_move_count,
    input  logic                         i_cfg_valid,
    input  logic [tcc_pkg::BYTE_W-1:0]   i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output tcc_pkg::t_rsp                o_out
);

    localparam int COL_W  = tcc_pkg::COL_W;
    localparam int ROW_W  = tcc_pkg::ROW_W;
    localparam int ADDR_W = tcc_pkg::ADDR_W;

    logic [tcc_pkg::CELL_W-1:0] mem [tcc_pkg::CELLS];

    logic [tcc_pkg::OPCODE_W-1:0] r_op;
    logic [tcc_pkg::BYTE_W-1:0]   r_ch, r_ca, r_ra, r_n;
    logic [tcc_pkg::BYTE_W-1:0]   r_color;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    logic                         r_vis, n_vis;
    logic [ADDR_W-1:0]            r_ptr;
    logic                         r_cp_pend;
    logic [ADDR_W-1:0]            r_cp_addr;
    logic [tcc_pkg::CELL_W-1:0]   r_rdata;
    logic                         r_out_valid;
    tcc_pkg::t_rsp                r_out;

    logic [ADDR_W-1:0]          cur_idx, rd_idx, rd_addr, wr_addr;
    logic [tcc_pkg::CELL_W-1:0] wr_data;
    logic                       wr_en, rd_en, ex_wr;
    logic [ADDR_W-1:0]          ex_addr;
    logic [tcc_pkg::BYTE_W-1:0] ex_char, right_lim, fill_attr;
    logic                       line_feed, scroll;
    logic [COL_W-1:0]           ca_clamp;
    logic [ROW_W-1:0]           ra_clamp;
    tcc_pkg::t_rsp              rsp;

    assign cur_idx  = tcc_pkg::cell_index(r_row, r_col);
    assign ca_clamp = (r_ca >= 8'(tcc_pkg::COLS)) ? COL_W'(tcc_pkg::COLS - 1) : COL_W'(r_ca);
    assign ra_clamp = (r_ra >= 8'(tcc_pkg::ROWS)) ? ROW_W'(tcc_pkg::ROWS - 1) : ROW_W'(r_ra);
    assign rd_idx   = tcc_pkg::cell_index(ra_clamp, ca_clamp);
    assign right_lim = 8'(tcc_pkg::COLS - 1) - 8'(r_col);

    // a put that ends the line: the cursor moves down a row, or the store scrolls on the last row
    assign line_feed = (r_op == tcc_pkg::OP_PUT) &&
                       ((r_ch == tcc_pkg::CHAR_NL) ||
                        ((r_ch != tcc_pkg::CHAR_CR) && (r_col == COL_W'(tcc_pkg::COLS - 1))));
    assign scroll    = line_feed && (r_row == ROW_W'(tcc_pkg::ROWS - 1));

    // cursor update and write of one operation
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_vis   = r_vis;
        ex_wr   = 1'b0;
        ex_addr = cur_idx;
        ex_char = r_ch;
        case (r_op)
            tcc_pkg::OP_PUT: begin
                if (r_ch == tcc_pkg::CHAR_CR) begin
                    n_col = '0;
                end else if (r_ch == tcc_pkg::CHAR_NL) begin
                    n_col = '0;
                end else begin
                    ex_wr = 1'b1;
                    n_col = line_feed ? '0 : r_col + COL_W'(1);
                end
                if (line_feed && !scroll) begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            tcc_pkg::OP_BKSP: begin
                if (r_col != '0) begin
                    n_col   = r_col - COL_W'(1);
                    ex_wr   = 1'b1;
                    ex_addr = cur_idx - ADDR_W'(1);
                    ex_char = tcc_pkg::CHAR_SP;
                end
            end
            tcc_pkg::OP_SETCUR: begin
                n_col = ca_clamp;
                n_row = ra_clamp;
            end
            tcc_pkg::OP_LEFT: begin
                n_col = (r_n >= 8'(r_col)) ? '0 : r_col - COL_W'(r_n);
            end
            tcc_pkg::OP_RIGHT: begin
                n_col = (r_n >= right_lim) ? COL_W'(tcc_pkg::COLS - 1) : r_col + COL_W'(r_n);
            end
            tcc_pkg::OP_PUTAT: begin
                ex_wr = 1'b1;
            end
            tcc_pkg::OP_CLEAR: begin
                n_col = '0;
                n_row = '0;
            end
            tcc_pkg::OP_SHOW: begin
                n_vis = (r_n == 8'd1);
            end
            default: begin
            end
        endcase
    end

    assign fill_attr = i_cmd.fill_init ? tcc_pkg::RESET_ATTR : r_color;

    // single write port: copy write, then sweep fill, then operation write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr;
        wr_data = {fill_attr, tcc_pkg::CHAR_SP};
        if (r_cp_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_cp_addr;
            wr_data = r_rdata;
        end else if (i_cmd.fill_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.exec && ex_wr) begin
            wr_en   = 1'b1;
            wr_addr = ex_addr;
            wr_data = {r_color, ex_char};
        end
    end

    assign rd_en   = i_cmd.copy_step || (i_cmd.exec && (r_op == tcc_pkg::OP_READ));
    assign rd_addr = i_cmd.copy_step ? r_ptr + ADDR_W'(tcc_pkg::COLS) : rd_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // result word for the current beat
    always_comb begin
        rsp              = '0;
        rsp.cursor_col   = tcc_pkg::CURSOR_COL_W'(r_col);
        rsp.cursor_row   = tcc_pkg::CURSOR_ROW_W'(r_row);
        rsp.cursor_index = tcc_pkg::CURSOR_INDEX_W'(cur_idx);
        rsp.cursor_shown = r_vis;
        rsp.last         = i_cmd.last;
        if (r_op == tcc_pkg::OP_PUT) begin
            rsp.echo_valid = 1'b1;
            rsp.echo_byte  = r_ch;
        end else if (r_op == tcc_pkg::OP_BKSP) begin
            rsp.echo_valid = 1'b1;
            rsp.echo_byte  = (i_cmd.beat == 2'd1) ? tcc_pkg::CHAR_SP : tcc_pkg::CHAR_BS;
        end else if (r_op == tcc_pkg::OP_READ) begin
            rsp.cell_data = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_ch <= i_char_code;
            r_ca <= i_col_arg;
            r_ra <= i_row_arg;
            r_n  <= i_move_count;
        end
        if (i_cmd.copy_step) begin
            r_cp_addr <= r_ptr;
        end
        if (i_cmd.emit) begin
            r_out <= rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= tcc_pkg::RESET_ATTR;
            r_col       <= '0;
            r_row       <= '0;
            r_vis       <= 1'b1;
            r_ptr       <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_col <= n_col;
                r_row <= n_row;
                r_vis <= n_vis;
            end
            if (i_cmd.ptr_zero) begin
                r_ptr <= '0;
            end else if (i_cmd.copy_step || i_cmd.fill_step) begin
                r_ptr <= r_ptr + ADDR_W'(1);
            end
            r_cp_pend <= i_cmd.copy_step;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts              = '0;
        o_sts.op_clear     = (r_op == tcc_pkg::OP_CLEAR);
        o_sts.op_bksp      = (r_op == tcc_pkg::OP_BKSP);
        o_sts.exec_scroll  = scroll;
        o_sts.ptr_copy_end = (r_ptr == ADDR_W'(tcc_pkg::CELLS - tcc_pkg::COLS - 1));
        o_sts.ptr_end      = (r_ptr == ADDR_W'(tcc_pkg::CELLS - 1));
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/text_console_controller.sv =====
// ----------------------------------------------------------------------------
// text_console_controller
// Text-mode console: 80x25 store of attribute/character cells with cursor.
// ----------------------------------------------------------------------------
// Operations enter on i_cmd (valid/ready), one word per operation; results
// leave on o_rsp (valid/ready), one word per result, the final word of an
// operation marked by last. Backspace gives three words, all else one.
// i_cfg writes the colour attribute byte and is always ready; write it only
// while no operation is in flight.
// A word is accepted, executed in the next cycle, and its result registered
// in the result state once the result register is free. Clear sweeps the
// store one cell a cycle; a put that scrolls copies rows up through the
// single read and write port of the store and then refills the last row.
// Reset homes and shows the cursor, sets the colour to 0x0A and then fills
// the store with blank cells, one a cycle, with i_cmd.ready low. The result
// register holds its word while o_rsp.ready is low; the next operation is
// still taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module text_console_controller (
    input logic        i_clk,
    input logic        i_rst_n,
    tcc_cmd_if.sink    i_cmd,
    tcc_rsp_if.source  o_rsp,
    tcc_cfg_if.sink    i_cfg
);

    tcc_pkg::t_cmd cmd;
    tcc_pkg::t_sts sts;
    tcc_pkg::t_rsp rsp;
    logic          in_ready;
    logic          out_valid;

    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    tcc_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_cmd.opcode),
        .i_char_code  (i_cmd.char_code),
        .i_col_arg    (i_cmd.col_arg),
        .i_row_arg    (i_cmd.row_arg),
        .i_move_count (i_cmd.move_count),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (out_valid),
        .o_out        (rsp)
    );

    assign i_cmd.ready        = in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = out_valid;
    assign o_rsp.echo_valid   = rsp.echo_valid;
    assign o_rsp.echo_byte    = rsp.echo_byte;
    assign o_rsp.cell_data    = rsp.cell_data;
    assign o_rsp.cursor_col   = rsp.cursor_col;
    assign o_rsp.cursor_row   = rsp.cursor_row;
    assign o_rsp.cursor_index = rsp.cursor_index;
    assign o_rsp.cursor_shown = rsp.cursor_shown;
    assign o_rsp.last         = rsp.last;

endmodule

// ===== rtl/core/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the console, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic [7:0]  i_out_echo_byte,
    input logic [6:0]  i_out_cursor_col,
    input logic [4:0]  i_out_cursor_row,
    input logic [10:0] i_out_cursor_index
);

    // a result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_echo_byte) &&
        $stable(i_out_last) && $stable(i_out_cursor_index))
        else $error("result word changed while stalled");

    // reset starts the blanking sweep, so no word is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("word taken during blanking sweep");

    // one operation at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while busy");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_cursor_index ==
        11'(int'(i_out_cursor_row) * tcc_pkg::COLS + int'(i_out_cursor_col)))
        else $error("cursor index does not match row and column");

    // backspace beats follow one another without a gap
    a_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap between result words of one operation");

endmodule

bind text_console_controller tcc_checker u_tcc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_cmd.valid),
    .i_in_ready         (i_cmd.ready),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_out_last         (o_rsp.last),
    .i_out_echo_byte    (o_rsp.echo_byte),
    .i_out_cursor_col   (o_rsp.cursor_col),
    .i_out_cursor_row   (o_rsp.cursor_row),
    .i_out_cursor_index (o_rsp.cursor_index)
);
